// File: design/battery_voltage_monitor_assert.svh
// ----------------------------------------------------------------------------
// battery voltage monitor assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_ASSERT_SVH

// same-cycle implication
`define BVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// shared types, register indexes, band codes and constants
// ----------------------------------------------------------------------------
package bvm_pkg;

	localparam int WINDOW_DEF     = 4;
	localparam int NOMINAL_MV_DEF = 12000;

	localparam int MV_W    = 16;
	localparam int HYST_W  = 12;
	localparam int BAND_W  = 3;
	localparam int PCT_W   = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WARN_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 3'd4;

	localparam logic [MV_W-1:0]   DISABLE_LOW_RST  = 16'd9000;
	localparam logic [MV_W-1:0]   WARN_LOW_RST     = 16'd10500;
	localparam logic [MV_W-1:0]   WARN_HIGH_RST    = 16'd15000;
	localparam logic [MV_W-1:0]   DISABLE_HIGH_RST = 16'd16000;
	localparam logic [HYST_W-1:0] HYSTERESIS_RST   = 12'd500;

	localparam logic [BAND_W-1:0] BAND_DIS_LO  = 3'd0;
	localparam logic [BAND_W-1:0] BAND_WARN_LO = 3'd1;
	localparam logic [BAND_W-1:0] BAND_NORMAL  = 3'd2;
	localparam logic [BAND_W-1:0] BAND_WARN_HI = 3'd3;
	localparam logic [BAND_W-1:0] BAND_DIS_HI  = 3'd4;

	localparam logic [MV_W-1:0]  SOC_FULL_MV  = 16'd12600;
	localparam logic [MV_W-1:0]  SOC_EMPTY_MV = 16'd10500;
	localparam logic [PCT_W-1:0] SOC_MAX      = 7'd100;
	// span 2100 mv over 100 percent is a divide by 21
	localparam int SOC_DIFF_W  = 12;
	localparam int SOC_SHIFT   = 16;
	localparam logic [11:0] SOC_RECIP = 12'd3121;

	typedef struct packed {
		logic [MV_W-1:0]   trip_lo;
		logic [MV_W-1:0]   alert_lo;
		logic [MV_W-1:0]   alert_hi;
		logic [MV_W-1:0]   trip_hi;
		logic [HYST_W-1:0] hysteresis;
	} cfg_t;

endpackage

// File: design/bvm_window.sv
// ----------------------------------------------------------------------------
// bvm_window
// sample ring with running sum, first pipeline stage
// ----------------------------------------------------------------------------
module bvm_window #(
	parameter int WINDOW     = bvm_pkg::WINDOW_DEF,
	parameter int NOMINAL_MV = bvm_pkg::NOMINAL_MV_DEF,
	parameter int SUM_W      = bvm_pkg::MV_W + $clog2(WINDOW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [bvm_pkg::MV_W-1:0] sample_mv,
	output logic                     vld_s1,
	output logic [SUM_W-1:0]         sum_s1,
	input  logic                     rdy_s2
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [bvm_pkg::MV_W-1:0] NOM = bvm_pkg::MV_W'(NOMINAL_MV);
	localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(WINDOW * NOMINAL_MV);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	logic [bvm_pkg::MV_W-1:0] ring_q [WINDOW];
	logic [SLOT_W-1:0]        slot_q;
	logic [SUM_W-1:0]         sum_q;
	logic                     vld_q;
	logic                     rdy_s1;
	logic                     accept;
	logic [SUM_W-1:0]         sum_nxt;

	assign rdy_s1   = !vld_q || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept   = in_valid && rdy_s1;
	assign sum_nxt  = sum_q + SUM_W'(sample_mv) - SUM_W'(ring_q[slot_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				ring_q[k] <= NOM;
			end
			slot_q <= '0;
			sum_q  <= SUM_RST;
			vld_q  <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_q <= in_valid;
			end
			if (accept) begin
				ring_q[slot_q] <= sample_mv;
				sum_q          <= sum_nxt;
				slot_q         <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// the running sum is the stage one payload
	assign vld_s1 = vld_q;
	assign sum_s1 = sum_q;

endmodule

// File: design/bvm_divide.sv
// ----------------------------------------------------------------------------
// bvm_divide
// sum over window length by reciprocal multiply and one correction step
// ----------------------------------------------------------------------------
module bvm_divide #(
	parameter int WINDOW = bvm_pkg::WINDOW_DEF,
	parameter int SUM_W  = bvm_pkg::MV_W + $clog2(WINDOW)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_s1,
	input  logic [SUM_W-1:0]         sum_s1,
	output logic                     rdy_s2,
	output logic                     vld_s3,
	output logic [bvm_pkg::MV_W-1:0] avg_s3,
	input  logic                     rdy_s4
);

	localparam int K      = SUM_W;
	localparam int RCP_W  = K + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam longint unsigned RCP_VAL = (64'd1 << K) / WINDOW;
	localparam logic [RCP_W-1:0] RECIP  = RCP_W'(RCP_VAL);
	localparam logic [SUM_W-1:0] WIN    = SUM_W'(WINDOW);

	logic                     vld_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic [SUM_W-1:0]         sum_s2;
	logic                     vld_q;
	logic [bvm_pkg::MV_W-1:0] avg_q;
	logic                     rdy_s3;
	logic [bvm_pkg::MV_W-1:0] q_est;
	logic [SUM_W-1:0]         rem;

	assign rdy_s3 = !vld_q || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			prod_s2 <= PROD_W'(sum_s1) * PROD_W'(RECIP);
			sum_s2  <= sum_s1;
		end
		if (rdy_s3 && vld_s2) begin
			avg_q <= (rem >= WIN) ? q_est + 1'b1 : q_est;
		end
	end

	// estimate is exact or one short
	assign q_est = prod_s2[K +: bvm_pkg::MV_W];
	assign rem   = sum_s2 - SUM_W'(SUM_W'(q_est) * WIN);

	assign vld_s3 = vld_q;
	assign avg_s3 = avg_q;

endmodule

// File: design/bvm_classify.sv
// ----------------------------------------------------------------------------
// bvm_classify
// band decision with hysteresis, charge estimate, result register
// ----------------------------------------------------------------------------
module bvm_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bvm_pkg::cfg_t              cfg,
	input  logic                       vld_s3,
	input  logic [bvm_pkg::MV_W-1:0]   avg_s3,
	output logic                       rdy_s4,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bvm_pkg::MV_W-1:0]   average_mv,
	output logic [bvm_pkg::BAND_W-1:0] band,
	output logic                       fault,
	output logic [bvm_pkg::PCT_W-1:0]  charge_percent
);

	localparam int EXT_W  = bvm_pkg::MV_W + 1;
	localparam int SOC_PW = bvm_pkg::SOC_DIFF_W + 12;

	logic                       vld_q;
	logic [bvm_pkg::MV_W-1:0]   avg_s4;
	logic [bvm_pkg::BAND_W-1:0] band_q;
	logic                       fault_q;
	logic [bvm_pkg::PCT_W-1:0]  charge_q;
	logic                       load;

	logic [EXT_W-1:0]           avg_x;
	logic [EXT_W-1:0]           avg_h;
	logic [EXT_W-1:0]           hyst_x;
	logic [bvm_pkg::BAND_W-1:0] raw_band;
	logic [bvm_pkg::BAND_W-1:0] new_band;
	logic [bvm_pkg::MV_W-1:0]   soc_diff;
	logic [SOC_PW-1:0]          soc_prod;
	logic [bvm_pkg::PCT_W-1:0]  target;

	assign rdy_s4 = !vld_q || !out_stall;
	assign load   = rdy_s4 && vld_s3;

	assign hyst_x = EXT_W'(cfg.hysteresis);
	assign avg_x  = EXT_W'(avg_s3);
	assign avg_h  = avg_x + hyst_x;

	always_comb begin
		if (avg_s3 < cfg.trip_lo) begin
			raw_band = bvm_pkg::BAND_DIS_LO;
		end else if (avg_s3 < cfg.alert_lo) begin
			raw_band = bvm_pkg::BAND_WARN_LO;
		end else if (avg_s3 < cfg.alert_hi) begin
			raw_band = bvm_pkg::BAND_NORMAL;
		end else if (avg_s3 < cfg.trip_hi) begin
			raw_band = bvm_pkg::BAND_WARN_HI;
		end else begin
			raw_band = bvm_pkg::BAND_DIS_HI;
		end

		new_band = raw_band;
		if (band_q == bvm_pkg::BAND_DIS_LO &&
				avg_x < EXT_W'(cfg.trip_lo) + hyst_x) begin
			new_band = bvm_pkg::BAND_DIS_LO;
		end
		if (band_q == bvm_pkg::BAND_WARN_LO && new_band == bvm_pkg::BAND_NORMAL &&
				avg_x < EXT_W'(cfg.alert_lo) + hyst_x) begin
			new_band = bvm_pkg::BAND_WARN_LO;
		end
		if (band_q == bvm_pkg::BAND_DIS_HI && avg_h >= EXT_W'(cfg.trip_hi)) begin
			new_band = bvm_pkg::BAND_DIS_HI;
		end
		if (band_q == bvm_pkg::BAND_WARN_HI && new_band == bvm_pkg::BAND_NORMAL &&
				avg_h >= EXT_W'(cfg.alert_hi)) begin
			new_band = bvm_pkg::BAND_WARN_HI;
		end
	end

	// divide by 21 through reciprocal, exact over the span
	assign soc_diff = avg_s3 - bvm_pkg::SOC_EMPTY_MV;
	assign soc_prod = SOC_PW'(soc_diff[bvm_pkg::SOC_DIFF_W-1:0]) * SOC_PW'(bvm_pkg::SOC_RECIP);

	always_comb begin
		if (avg_s3 >= bvm_pkg::SOC_FULL_MV) begin
			target = bvm_pkg::SOC_MAX;
		end else if (avg_s3 <= bvm_pkg::SOC_EMPTY_MV) begin
			target = '0;
		end else begin
			target = soc_prod[bvm_pkg::SOC_SHIFT +: bvm_pkg::PCT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= 1'b0;
			band_q   <= bvm_pkg::BAND_NORMAL;
			fault_q  <= 1'b0;
			charge_q <= bvm_pkg::SOC_MAX;
		end else begin
			if (rdy_s4) begin
				vld_q <= vld_s3;
			end
			if (load) begin
				band_q  <= new_band;
				fault_q <= (new_band == bvm_pkg::BAND_DIS_LO) ||
					(new_band == bvm_pkg::BAND_DIS_HI);
				if (target < charge_q) begin
					charge_q <= target;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			avg_s4 <= avg_s3;
		end
	end

	assign out_valid      = vld_q;
	assign average_mv     = avg_s4;
	assign band           = band_q;
	assign fault          = fault_q;
	assign charge_percent = charge_q;

endmodule

// File: design/battery_voltage_monitor.sv
// flow: each accepted sample word is registered in every stage in turn
// throughput: one sample per cycle unless in_stall is high, set by the four-stage
//   pipeline (running sum, reciprocal multiply, correction, band and charge)
// reset: ring holds the nominal voltage, band normal, charge 100 percent,
//   registers at their documented reset values; no clearing pass
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// moving average over a sample ring, banded with hysteresis, charge estimate
// ----------------------------------------------------------------------------
module battery_voltage_monitor #(
	parameter int WINDOW     = bvm_pkg::WINDOW_DEF,
	parameter int NOMINAL_MV = bvm_pkg::NOMINAL_MV_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bvm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bvm_pkg::MV_W-1:0]       sample_mv,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bvm_pkg::MV_W-1:0]       average_mv,
	output logic [bvm_pkg::BAND_W-1:0]     band,
	output logic                           fault,
	output logic [bvm_pkg::PCT_W-1:0]      charge_percent
);

	localparam int SUM_W = bvm_pkg::MV_W + $clog2(WINDOW);

	bvm_pkg::cfg_t            cfg_q;
	logic                     vld_s1;
	logic [SUM_W-1:0]         sum_s1;
	logic                     rdy_s2;
	logic                     vld_s3;
	logic [bvm_pkg::MV_W-1:0] avg_s3;
	logic                     rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trip_lo    <= bvm_pkg::DISABLE_LOW_RST;
			cfg_q.alert_lo   <= bvm_pkg::WARN_LOW_RST;
			cfg_q.alert_hi   <= bvm_pkg::WARN_HIGH_RST;
			cfg_q.trip_hi    <= bvm_pkg::DISABLE_HIGH_RST;
			cfg_q.hysteresis <= bvm_pkg::HYSTERESIS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				bvm_pkg::CFG_DISABLE_LOW:  cfg_q.trip_lo  <= cfg_data;
				bvm_pkg::CFG_WARN_LOW:     cfg_q.alert_lo <= cfg_data;
				bvm_pkg::CFG_WARN_HIGH:    cfg_q.alert_hi <= cfg_data;
				bvm_pkg::CFG_DISABLE_HIGH: cfg_q.trip_hi  <= cfg_data;
				bvm_pkg::CFG_HYSTERESIS:
					cfg_q.hysteresis <= cfg_data[bvm_pkg::HYST_W-1:0];
				default: ;
			endcase
		end
	end

	bvm_window #(
		.WINDOW     (WINDOW),
		.NOMINAL_MV (NOMINAL_MV),
		.SUM_W      (SUM_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_mv (sample_mv),
		.vld_s1    (vld_s1),
		.sum_s1    (sum_s1),
		.rdy_s2    (rdy_s2)
	);

	bvm_divide #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_divide (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.sum_s1 (sum_s1),
		.rdy_s2 (rdy_s2),
		.vld_s3 (vld_s3),
		.avg_s3 (avg_s3),
		.rdy_s4 (rdy_s4)
	);

	bvm_classify u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.vld_s3         (vld_s3),
		.avg_s3         (avg_s3),
		.rdy_s4         (rdy_s4),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.average_mv     (average_mv),
		.band           (band),
		.fault          (fault),
		.charge_percent (charge_percent)
	);

endmodule

// File: design/bvm_checker.sv
// ----------------------------------------------------------------------------
// bvm_checker
// port-level checks on result words, bound to the top level
// ----------------------------------------------------------------------------
`include "battery_voltage_monitor_assert.svh"

module bvm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [bvm_pkg::MV_W-1:0]       average_mv,
	input logic [bvm_pkg::BAND_W-1:0]     band,
	input logic                           fault,
	input logic [bvm_pkg::PCT_W-1:0]      charge_percent
);

	// a held result word keeps its fields
	`BVM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(average_mv) && $stable(band) && $stable(fault) &&
		$stable(charge_percent), "result word changed while stalled")

	`BVM_ASSERT_NOW(a_fault, clk, arst_n, out_valid,
		fault == (band == bvm_pkg::BAND_DIS_LO || band == bvm_pkg::BAND_DIS_HI),
		"fault disagrees with band")

	`BVM_ASSERT_NOW(a_band, clk, arst_n, out_valid, band <= bvm_pkg::BAND_DIS_HI,
		"band out of range")

	`BVM_ASSERT_NOW(a_pct, clk, arst_n, out_valid, charge_percent <= bvm_pkg::SOC_MAX,
		"charge above full")

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.average_mv     (average_mv),
	.band           (band),
	.fault          (fault),
	.charge_percent (charge_percent)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives sample words into the battery voltage monitor under random gaps
// and output stalls, predicts each reading from a model of its own with a
// shadow of the threshold registers, and checks every reading field by field
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MV_W       = bvm_pkg::MV_W;
	localparam int BAND_W     = bvm_pkg::BAND_W;
	localparam int PCT_W      = bvm_pkg::PCT_W;
	localparam int HYST_W     = bvm_pkg::HYST_W;
	localparam int CFG_IDX_W  = bvm_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = bvm_pkg::CFG_DATA_W;

	localparam int CLK_HALF_NS     = 2;
	localparam int RESET_CYCLES    = 10;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RING_DEPTH      = bvm_pkg::WINDOW_DEF;
	localparam logic [MV_W-1:0] MV_MAX = '1;

	typedef struct packed {
		logic [MV_W-1:0]   mv;
		logic [BAND_W-1:0] band_code;
		logic              fault_flag;
		logic [PCT_W-1:0]  charge;
	} reading_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [MV_W-1:0]       sample_mv  = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [MV_W-1:0]       average_mv;
	logic [BAND_W-1:0]     band;
	logic                  fault;
	logic [PCT_W-1:0]      charge_percent;

	// predictor state and register shadow
	bvm_pkg::cfg_t shadow = '{bvm_pkg::DISABLE_LOW_RST, bvm_pkg::WARN_LOW_RST,
		bvm_pkg::WARN_HIGH_RST, bvm_pkg::DISABLE_HIGH_RST, bvm_pkg::HYSTERESIS_RST};
	logic [MV_W-1:0]   ring_mv [RING_DEPTH] = '{default: MV_W'(bvm_pkg::NOMINAL_MV_DEF)};
	int                ring_slot = 0;
	logic [BAND_W-1:0] held_band = bvm_pkg::BAND_NORMAL;
	logic [PCT_W-1:0]  soc_floor = bvm_pkg::SOC_MAX;

	reading_t pending_readings [$];
	reading_t want;

	int send_gap_pct    = 0;
	int stall_pct       = 0;
	int hold_off_grants = 0;
	int hold_off_served = 0;
	int hold_left       = 0;
	int fail_count      = 0;
	int checked_count   = 0;
	int sent_count      = 0;
	int setting_count   = 0;
	int cycle_count     = 0;

	battery_voltage_monitor dut (.*);

	always begin
		#(CLK_HALF_NS) clk = 1'b1;
		#(CLK_HALF_NS) clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic reading_t predict_reading(input logic [MV_W-1:0] mv);
		int unsigned       total;
		int unsigned       avg;
		int unsigned       h;
		int unsigned       target;
		int                k;
		logic [BAND_W-1:0] next_band;
		reading_t          r;
		ring_mv[ring_slot] = mv;
		ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
		total = 0;
		for (k = 0; k < RING_DEPTH; k++)
			total += 32'(ring_mv[k]);
		avg = total / RING_DEPTH;
		h = 32'(shadow.hysteresis);
		if (avg < shadow.trip_lo)
			next_band = bvm_pkg::BAND_DIS_LO;
		else if (avg < shadow.alert_lo)
			next_band = bvm_pkg::BAND_WARN_LO;
		else if (avg < shadow.alert_hi)
			next_band = bvm_pkg::BAND_NORMAL;
		else if (avg < shadow.trip_hi)
			next_band = bvm_pkg::BAND_WARN_HI;
		else
			next_band = bvm_pkg::BAND_DIS_HI;
		// margins taken at 32 bits so they never wrap
		if (held_band == bvm_pkg::BAND_DIS_LO && avg < shadow.trip_lo + h)
			next_band = bvm_pkg::BAND_DIS_LO;
		if (held_band == bvm_pkg::BAND_WARN_LO && next_band == bvm_pkg::BAND_NORMAL
				&& avg < shadow.alert_lo + h)
			next_band = bvm_pkg::BAND_WARN_LO;
		if (held_band == bvm_pkg::BAND_DIS_HI && avg + h >= shadow.trip_hi)
			next_band = bvm_pkg::BAND_DIS_HI;
		if (held_band == bvm_pkg::BAND_WARN_HI && next_band == bvm_pkg::BAND_NORMAL
				&& avg + h >= shadow.alert_hi)
			next_band = bvm_pkg::BAND_WARN_HI;
		held_band = next_band;
		if (avg >= bvm_pkg::SOC_FULL_MV)
			target = 32'(bvm_pkg::SOC_MAX);
		else if (avg <= bvm_pkg::SOC_EMPTY_MV)
			target = 0;
		else
			target = (avg - bvm_pkg::SOC_EMPTY_MV) * bvm_pkg::SOC_MAX
				/ (bvm_pkg::SOC_FULL_MV - bvm_pkg::SOC_EMPTY_MV);
		if (target < soc_floor)
			soc_floor = target[PCT_W-1:0];
		r.mv = avg[MV_W-1:0];
		r.band_code = held_band;
		r.fault_flag = (held_band == bvm_pkg::BAND_DIS_LO) ||
			(held_band == bvm_pkg::BAND_DIS_HI);
		r.charge = soc_floor;
		return r;
	endfunction

	function automatic logic [MV_W-1:0] to_mv(input int v);
		if (v < 0)
			return '0;
		if (v > int'(MV_MAX))
			return MV_MAX;
		return v[MV_W-1:0];
	endfunction

	// a level near one of the thresholds, or now and then a rail
	function automatic int pick_focus();
		int              span;
		logic [MV_W-1:0] thr;
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) != 0) ? int'(MV_MAX) : 0;
		case ($urandom_range(0, 3))
			0: thr = shadow.trip_lo;
			1: thr = shadow.alert_lo;
			2: thr = shadow.alert_hi;
			default: thr = shadow.trip_hi;
		endcase
		span = int'(shadow.hysteresis) + 200;
		return int'(thr) + int'($urandom_range(0, 2 * span)) - span;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				$error("reading word with none expected: average_mv %0d band %0d",
					average_mv, band);
				fail_count++;
			end else begin
				want = pending_readings.pop_front();
				checked_count++;
				if (average_mv !== want.mv) begin
					$error("average_mv: expected %0d, actual %0d", want.mv, average_mv);
					fail_count++;
				end
				if (band !== want.band_code) begin
					$error("band: expected %0d, actual %0d", want.band_code, band);
					fail_count++;
				end
				if (fault !== want.fault_flag) begin
					$error("fault: expected %0d, actual %0d", want.fault_flag, fault);
					fail_count++;
				end
				if (charge_percent !== want.charge) begin
					$error("charge_percent: expected %0d, actual %0d", want.charge,
						charge_percent);
					fail_count++;
				end
			end
		end
	end

	// receiver stalls, with a counted hold-off when one is granted
	always @(posedge clk) begin
		if (hold_off_served != hold_off_grants) begin
			hold_off_served++;
			hold_left = HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_gap_pct = send_pct;
		stall_pct <= recv_pct;
	endtask

	task automatic send_sample(input logic [MV_W-1:0] mv);
		while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_mv <= mv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_readings.push_back(predict_reading(mv));
		sent_count++;
	endtask

	task automatic send_repeat(input logic [MV_W-1:0] mv, input int count);
		repeat (count) send_sample(mv);
	endtask

	// runs of a level with jitter so the average settles, plus raw noise
	task automatic send_runs(input int count);
		int sent;
		int target;
		int run_len;
		int k;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 15) begin
				send_sample(MV_W'($urandom));
				sent++;
			end else begin
				target = pick_focus();
				run_len = $urandom_range(2, 8);
				for (k = 0; k < run_len; k++) begin
					send_sample(to_mv(target + int'($urandom_range(0, 100)) - 50));
					sent++;
				end
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			bvm_pkg::CFG_DISABLE_LOW: shadow.trip_lo = data;
			bvm_pkg::CFG_WARN_LOW: shadow.alert_lo = data;
			bvm_pkg::CFG_WARN_HIGH: shadow.alert_hi = data;
			bvm_pkg::CFG_DISABLE_HIGH: shadow.trip_hi = data;
			bvm_pkg::CFG_HYSTERESIS: shadow.hysteresis = data[HYST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [MV_W-1:0] dl, input logic [MV_W-1:0] wl,
			input logic [MV_W-1:0] wh, input logic [MV_W-1:0] dh,
			input logic [CFG_DATA_W-1:0] hy);
		write_reg(bvm_pkg::CFG_DISABLE_LOW, dl);
		write_reg(bvm_pkg::CFG_WARN_LOW, wl);
		write_reg(bvm_pkg::CFG_WARN_HIGH, wh);
		write_reg(bvm_pkg::CFG_DISABLE_HIGH, dh);
		write_reg(bvm_pkg::CFG_HYSTERESIS, hy);
		end_writes();
		setting_count++;
	endtask

	// high rail, disable high held inside the margin, warn high held
	task automatic test_band_edges_high();
		send_repeat(MV_MAX, 4);
		send_repeat(bvm_pkg::DISABLE_HIGH_RST - 16'd400, 4);
		send_repeat(bvm_pkg::WARN_HIGH_RST - 16'd400, 4);
		drain();
	endtask

	// slow fall through the charge range
	task automatic test_charge_descent();
		int k;
		for (k = 0; k < 100; k++)
			send_sample(to_mv(int'(bvm_pkg::SOC_FULL_MV) + 100 - 22 * k
				+ int'($urandom_range(0, 30)) - 15));
		drain();
	endtask

	// low rail, disable low held inside the margin, then a jump to the top
	task automatic test_band_edges_low();
		send_repeat('0, 4);
		send_repeat(bvm_pkg::DISABLE_LOW_RST + 16'd400, 4);
		send_sample(MV_MAX);
		drain();
	endtask

	// thresholds at both rails, margin masked to its width
	task automatic test_register_extremes();
		apply_settings('0, '0, '0, '0, '1);
		send_runs(40);
		drain();
		apply_settings(MV_MAX, MV_MAX, MV_MAX, MV_MAX, 16'hF000);
		send_runs(40);
		drain();
	endtask

	task automatic test_unordered_thresholds();
		logic [MV_W-1:0] t0;
		logic [MV_W-1:0] t1;
		logic [MV_W-1:0] t2;
		t0 = MV_W'($urandom_range(30000, 65535));
		t1 = t0 - 16'($urandom_range(0, 8000));
		t2 = t1 - 16'($urandom_range(0, 8000));
		apply_settings(t0, t1, t2, t2 - 16'($urandom_range(0, 8000)),
			{4'($urandom), 12'($urandom_range(0, 1500))});
		send_runs(40);
		drain();
		apply_settings(MV_W'($urandom), MV_W'($urandom), MV_W'($urandom), MV_W'($urandom),
			CFG_DATA_W'($urandom));
		send_runs(40);
		drain();
	endtask

	task automatic test_unused_index();
		int idx;
		for (idx = int'(bvm_pkg::CFG_HYSTERESIS) + 1; idx < (1 << CFG_IDX_W); idx++)
			write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
		end_writes();
		send_runs(40);
		drain();
	endtask

	// output held off long enough for the pipeline to back up into the input
	task automatic test_backpressure();
		set_idling(0, 0);
		hold_off_grants <= hold_off_grants + 1;
		send_runs(40);
		drain();
	endtask

	task automatic test_random_thresholds(input int phases);
		logic [MV_W-1:0] dl;
		logic [MV_W-1:0] wl;
		logic [MV_W-1:0] wh;
		repeat (phases) begin
			dl = MV_W'($urandom_range(0, 40000));
			wl = dl + 16'($urandom_range(0, 8000));
			wh = wl + 16'($urandom_range(0, 8000));
			apply_settings(dl, wl, wh, wh + 16'($urandom_range(0, 8000)),
				{4'($urandom), 12'($urandom_range(0, 1500))});
			send_runs(90);
			drain();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(28, 71);
		test_band_edges_high();
		test_charge_descent();
		test_band_edges_low();
		test_register_extremes();
		test_unordered_thresholds();

		set_idling(71, 28);
		test_unused_index();
		test_backpressure();
		set_idling(71, 28);
		test_random_thresholds(4);

		set_idling(0, 0);
		test_random_thresholds(3);

		$display("%0d sample words in, %0d reading words checked, %0d register settings",
			sent_count, checked_count, setting_count);
		$display("band holds, charge fall, rail and unordered thresholds, unused indexes, "
			, "long output hold-off");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
